FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked during reset too
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ifsb_pkg.sv
// shared types and constants for the inverse fft split butterfly
package ifsb_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int TWIDDLE_FRAC_DEF = 30;
    localparam int CFG_W            = 32;
    localparam int TW_W             = CFG_W + 1;
    localparam int CFG_IDX_W        = 3;
    localparam int BFLY_LAT         = 5;
    localparam int PIPE_LAT         = 2 * BFLY_LAT + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYER_MODE = 3'd0,
        REG_W0_REAL    = 3'd1,
        REG_W0_IMAG    = 3'd2,
        REG_W1_REAL    = 3'd3,
        REG_W1_IMAG    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                    layer_mode;
        logic signed [CFG_W-1:0] w0_re;
        logic signed [CFG_W-1:0] w0_im;
        logic signed [CFG_W-1:0] w1_re;
        logic signed [CFG_W-1:0] w1_im;
    } t_cfg;

endpackage

FILE: rtl/ifsb_cfg.sv
// configuration registers: layer mode and the two twiddles
module ifsb_cfg import ifsb_pkg::*; #(
    parameter int FRAC_W = TWIDDLE_FRAC_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [CFG_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    localparam logic signed [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_W;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layer_mode <= 1'b0;
            r_cfg.w0_re      <= ONE;
            r_cfg.w0_im      <= '0;
            r_cfg.w1_re      <= ONE;
            r_cfg.w1_im      <= '0;
        end else if (i_we) begin
            unique case (t_reg_idx'(i_idx))
                REG_LAYER_MODE: r_cfg.layer_mode <= i_data[0];
                REG_W0_REAL:    r_cfg.w0_re      <= i_data;
                REG_W0_IMAG:    r_cfg.w0_im      <= i_data;
                REG_W1_REAL:    r_cfg.w1_re      <= i_data;
                REG_W1_IMAG:    r_cfg.w1_im      <= i_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/ifsb_bfly.sv
// five-stage pipelined radix-2 butterfly: a+b and (a-b)*w, rounded and saturated
module ifsb_bfly import ifsb_pkg::*; #(
    parameter int IN_W   = SAMPLE_WIDTH_DEF,
    parameter int RES_W  = SAMPLE_WIDTH_DEF + 4,
    parameter int FRAC_W = TWIDDLE_FRAC_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [IN_W-1:0]  i_a_re,
    input  logic signed [IN_W-1:0]  i_a_im,
    input  logic signed [IN_W-1:0]  i_b_re,
    input  logic signed [IN_W-1:0]  i_b_im,
    input  logic signed [TW_W-1:0]  i_w_re,
    input  logic signed [TW_W-1:0]  i_w_im,
    output logic                    o_valid,
    output logic signed [RES_W-1:0] o_sum_re,
    output logic signed [RES_W-1:0] o_sum_im,
    output logic signed [RES_W-1:0] o_prod_re,
    output logic signed [RES_W-1:0] o_prod_im
);

    localparam int DW   = IN_W + 1;
    localparam int LO_W = DW / 2;
    localparam int HI_W = DW - LO_W;
    localparam int HP_W = HI_W + TW_W;
    localparam int LP_W = LO_W + 1 + TW_W;
    localparam int PW   = DW + TW_W;
    localparam int AW   = PW + 1;
    localparam int SH_W = AW - FRAC_W;
    localparam int EW   = (IN_W > RES_W) ? IN_W + 1 : RES_W + 1;

    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic signed [AW-1:0]    HALF    = AW'(1) << (FRAC_W - 1);

    function automatic logic signed [RES_W-1:0] sat_sum(input logic signed [EW-1:0] v);
        logic [EW-RES_W:0] top;
        top = v[EW-1:RES_W-1];
        if ((&top) || !(|top)) sat_sum = v[RES_W-1:0];
        else                   sat_sum = v[EW-1] ? RES_MIN : RES_MAX;
    endfunction

    function automatic logic signed [RES_W-1:0] sat_prod(input logic signed [SH_W-1:0] v);
        logic [SH_W-RES_W:0] top;
        top = v[SH_W-1:RES_W-1];
        if ((&top) || !(|top)) sat_prod = v[RES_W-1:0];
        else                   sat_prod = v[SH_W-1] ? RES_MIN : RES_MAX;
    endfunction

    // valid bits per stage
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;

    // stage 1: sum and exact difference
    logic signed [EW-1:0]    n_sum_re, n_sum_im;
    logic signed [RES_W-1:0] r1_sum_re, r1_sum_im;
    logic signed [DW-1:0]    r1_dr, r1_di;
    logic signed [TW_W-1:0]  r1_wr, r1_wi;

    assign n_sum_re = EW'(i_a_re) + EW'(i_b_re);
    assign n_sum_im = EW'(i_a_im) + EW'(i_b_im);

    // stage 2: partial products, difference split into signed high and unsigned low half
    logic signed [HI_W-1:0]  dr_h, di_h;
    logic signed [LO_W:0]    dr_l, di_l;
    logic signed [HP_W-1:0]  r2_rr_h, r2_ii_h, r2_ri_h, r2_ir_h;
    logic signed [LP_W-1:0]  r2_rr_l, r2_ii_l, r2_ri_l, r2_ir_l;
    logic signed [RES_W-1:0] r2_sum_re, r2_sum_im;

    assign dr_h = r1_dr[DW-1:LO_W];
    assign di_h = r1_di[DW-1:LO_W];
    assign dr_l = {1'b0, r1_dr[LO_W-1:0]};
    assign di_l = {1'b0, r1_di[LO_W-1:0]};

    // stage 3: whole products
    logic signed [PW-1:0]    r3_rr, r3_ii, r3_ri, r3_ir;
    logic signed [RES_W-1:0] r3_sum_re, r3_sum_im;

    // stage 4: complex product plus rounding half
    logic signed [AW-1:0]    r4_re, r4_im;
    logic signed [RES_W-1:0] r4_sum_re, r4_sum_im;

    // stage 5: shift and saturate
    logic signed [RES_W-1:0] r5_sum_re, r5_sum_im, r5_prod_re, r5_prod_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r1_sum_re <= sat_sum(n_sum_re);
            r1_sum_im <= sat_sum(n_sum_im);
            r1_dr     <= DW'(i_a_re) - DW'(i_b_re);
            r1_di     <= DW'(i_a_im) - DW'(i_b_im);
            r1_wr     <= i_w_re;
            r1_wi     <= i_w_im;
        end
        if (r1_vld) begin
            r2_rr_h   <= HP_W'(dr_h) * HP_W'(r1_wr);
            r2_ii_h   <= HP_W'(di_h) * HP_W'(r1_wi);
            r2_ri_h   <= HP_W'(dr_h) * HP_W'(r1_wi);
            r2_ir_h   <= HP_W'(di_h) * HP_W'(r1_wr);
            r2_rr_l   <= LP_W'(dr_l) * LP_W'(r1_wr);
            r2_ii_l   <= LP_W'(di_l) * LP_W'(r1_wi);
            r2_ri_l   <= LP_W'(dr_l) * LP_W'(r1_wi);
            r2_ir_l   <= LP_W'(di_l) * LP_W'(r1_wr);
            r2_sum_re <= r1_sum_re;
            r2_sum_im <= r1_sum_im;
        end
        if (r2_vld) begin
            r3_rr     <= $signed({r2_rr_h, {LO_W{1'b0}}}) + PW'(r2_rr_l);
            r3_ii     <= $signed({r2_ii_h, {LO_W{1'b0}}}) + PW'(r2_ii_l);
            r3_ri     <= $signed({r2_ri_h, {LO_W{1'b0}}}) + PW'(r2_ri_l);
            r3_ir     <= $signed({r2_ir_h, {LO_W{1'b0}}}) + PW'(r2_ir_l);
            r3_sum_re <= r2_sum_re;
            r3_sum_im <= r2_sum_im;
        end
        if (r3_vld) begin
            r4_re     <= AW'(r3_rr) - AW'(r3_ii) + HALF;
            r4_im     <= AW'(r3_ri) + AW'(r3_ir) + HALF;
            r4_sum_re <= r3_sum_re;
            r4_sum_im <= r3_sum_im;
        end
        if (r4_vld) begin
            r5_prod_re <= sat_prod(r4_re[AW-1:FRAC_W]);
            r5_prod_im <= sat_prod(r4_im[AW-1:FRAC_W]);
            r5_sum_re  <= r4_sum_re;
            r5_sum_im  <= r4_sum_im;
        end
    end

    assign o_valid   = r5_vld;
    assign o_sum_re  = r5_sum_re;
    assign o_sum_im  = r5_sum_im;
    assign o_prod_re = r5_prod_re;
    assign o_prod_im = r5_prod_im;

endmodule

FILE: rtl/inverse_fft_split_butterfly_top.sv
// top level of the inverse fft split butterfly pipeline
//
// Takes one group of four complex samples per clock while busy is low and
// returns the split butterfly results, one group per cycle sustained. Each
// of the two butterfly layers is a five-stage pipeline (difference, partial
// products, product assembly, rounding add, shift and saturate); one output
// register follows. In mode 0 the second layer is bypassed through a
// matching five-stage delay line, so latency is the same in both modes.
// Results show on the y ports for exactly one cycle with o_strobe high; the
// receiver cannot stall the block, so it must take every strobed result.
// busy is high only during reset and until the registered ready flag comes
// up after it; otherwise a request is taken on every cycle that start is
// high. Twiddles are Q1.TWIDDLE_FRAC_BITS, products round to nearest (ties
// up) and every result saturates to SAMPLE_WIDTH+4 bits. The user must
// write configuration registers through the cfg port only while no request
// is in flight; the block itself does not enforce this.
module inverse_fft_split_butterfly_top import ifsb_pkg::*; #(
    parameter int SAMPLE_WIDTH      = SAMPLE_WIDTH_DEF,
    parameter int TWIDDLE_FRAC_BITS = TWIDDLE_FRAC_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request handshake
    input  logic                           start,
    output logic                           busy,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [CFG_W-1:0]               i_cfg_data,
    // request payload
    input  logic signed [SAMPLE_WIDTH-1:0] i_x0_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x0_im,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x1_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x1_im,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x2_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x2_im,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x3_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x3_im,
    input  logic                           i_last_in,
    // results
    output logic                           o_strobe,
    output logic signed [SAMPLE_WIDTH+3:0] o_y0_re,
    output logic signed [SAMPLE_WIDTH+3:0] o_y0_im,
    output logic signed [SAMPLE_WIDTH+3:0] o_y1_re,
    output logic signed [SAMPLE_WIDTH+3:0] o_y1_im,
    output logic signed [SAMPLE_WIDTH+3:0] o_y2_re,
    output logic signed [SAMPLE_WIDTH+3:0] o_y2_im,
    output logic signed [SAMPLE_WIDTH+3:0] o_y3_re,
    output logic signed [SAMPLE_WIDTH+3:0] o_y3_im,
    output logic                           o_last_out
);

    localparam int RES_W = SAMPLE_WIDTH + 4;
    localparam int NVAL  = 8;   // re/im of four results

    t_cfg cfg;

    ifsb_cfg #(
        .FRAC_W (TWIDDLE_FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // ready flag comes up in the cycle after reset is released
    logic r_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ready <= 1'b0;
        else          r_ready <= 1'b1;
    end

    logic accept;
    assign busy   = !r_ready;
    assign accept = start && r_ready;

    // twiddles: w0 for the first pair, -i*w0 for the second pair in bisplit mode
    logic signed [TW_W-1:0] w0_re, w0_im, wb_re, wb_im, w1_re, w1_im;
    assign w0_re = TW_W'(cfg.w0_re);
    assign w0_im = TW_W'(cfg.w0_im);
    assign w1_re = TW_W'(cfg.w1_re);
    assign w1_im = TW_W'(cfg.w1_im);
    assign wb_re = cfg.layer_mode ? w0_im : w0_re;
    assign wb_im = cfg.layer_mode ? -w0_re : w0_im;

    // first layer: (x0,x1) and (x2,x3)
    logic                    l1a_vld, l1b_vld;
    logic signed [RES_W-1:0] l1 [NVAL];

    ifsb_bfly #(
        .IN_W   (SAMPLE_WIDTH),
        .RES_W  (RES_W),
        .FRAC_W (TWIDDLE_FRAC_BITS)
    ) u_l1a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_a_re    (i_x0_re),
        .i_a_im    (i_x0_im),
        .i_b_re    (i_x1_re),
        .i_b_im    (i_x1_im),
        .i_w_re    (w0_re),
        .i_w_im    (w0_im),
        .o_valid   (l1a_vld),
        .o_sum_re  (l1[0]),
        .o_sum_im  (l1[1]),
        .o_prod_re (l1[2]),
        .o_prod_im (l1[3])
    );

    ifsb_bfly #(
        .IN_W   (SAMPLE_WIDTH),
        .RES_W  (RES_W),
        .FRAC_W (TWIDDLE_FRAC_BITS)
    ) u_l1b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_a_re    (i_x2_re),
        .i_a_im    (i_x2_im),
        .i_b_re    (i_x3_re),
        .i_b_im    (i_x3_im),
        .i_w_re    (wb_re),
        .i_w_im    (wb_im),
        .o_valid   (l1b_vld),
        .o_sum_re  (l1[4]),
        .o_sum_im  (l1[5]),
        .o_prod_re (l1[6]),
        .o_prod_im (l1[7])
    );

    // second layer: (e0,e2) and (e1,e3) with w1
    logic                    l2a_vld, l2b_vld;
    logic signed [RES_W-1:0] l2 [NVAL];

    ifsb_bfly #(
        .IN_W   (RES_W),
        .RES_W  (RES_W),
        .FRAC_W (TWIDDLE_FRAC_BITS)
    ) u_l2a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (l1a_vld),
        .i_a_re    (l1[0]),
        .i_a_im    (l1[1]),
        .i_b_re    (l1[4]),
        .i_b_im    (l1[5]),
        .i_w_re    (w1_re),
        .i_w_im    (w1_im),
        .o_valid   (l2a_vld),
        .o_sum_re  (l2[0]),
        .o_sum_im  (l2[1]),
        .o_prod_re (l2[4]),
        .o_prod_im (l2[5])
    );

    ifsb_bfly #(
        .IN_W   (RES_W),
        .RES_W  (RES_W),
        .FRAC_W (TWIDDLE_FRAC_BITS)
    ) u_l2b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (l1b_vld),
        .i_a_re    (l1[2]),
        .i_a_im    (l1[3]),
        .i_b_re    (l1[6]),
        .i_b_im    (l1[7]),
        .i_w_re    (w1_re),
        .i_w_im    (w1_im),
        .o_valid   (l2b_vld),
        .o_sum_re  (l2[2]),
        .o_sum_im  (l2[3]),
        .o_prod_re (l2[6]),
        .o_prod_im (l2[7])
    );

    // bypass delay for mode 0, same depth as one butterfly
    logic signed [RES_W-1:0] r_dly [BFLY_LAT][NVAL];
    always_ff @(posedge i_clk) begin
        r_dly[0] <= l1;
        for (int k = 1; k < BFLY_LAT; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // last flag rides alongside the whole pipeline
    logic [PIPE_LAT-1:0] r_last;
    always_ff @(posedge i_clk) begin
        r_last <= {r_last[PIPE_LAT-2:0], i_last_in};
    end

    // output register
    logic                    r_out_vld;
    logic signed [RES_W-1:0] r_y [NVAL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else          r_out_vld <= l2a_vld && l2b_vld;
    end

    always_ff @(posedge i_clk) begin
        if (l2a_vld) begin
            if (cfg.layer_mode) begin
                r_y <= l2;
            end else begin
                r_y <= r_dly[BFLY_LAT-1];
            end
        end
    end

    assign o_strobe   = r_out_vld;
    assign o_last_out = r_last[PIPE_LAT-1];
    assign o_y0_re    = r_y[0];
    assign o_y0_im    = r_y[1];
    assign o_y1_re    = r_y[2];
    assign o_y1_im    = r_y[3];
    assign o_y2_re    = r_y[4];
    assign o_y2_im    = r_y[5];
    assign o_y3_re    = r_y[6];
    assign o_y3_im    = r_y[7];

endmodule

FILE: rtl/ifsb_checker.sv
// port-level timing checks for the split butterfly pipeline, with bind
`include "assert_macros.svh"

module ifsb_checker import ifsb_pkg::*; #(
    parameter int LAT = PIPE_LAT
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    // reset flushes the pipeline
    `ASSERT_NEXT_ALWAYS(a_rst_flush, i_clk, !i_rst_n, !o_strobe)
    // every strobe traces back to a request a fixed latency earlier
    `ASSERT_IMPL(a_strobe_has_req, i_clk, i_rst_n, o_strobe, $past(start && !busy, LAT))
    // every request comes out after exactly the latency
    `ASSERT_IMPL(a_req_gives_strobe, i_clk, i_rst_n, start && !busy, ##LAT o_strobe)
    // busy is low whenever reset was already released when last sampled
    `ASSERT_IMPL(a_ready_after_rst, i_clk, i_rst_n, $past(i_rst_n), !busy)

endmodule

bind inverse_fft_split_butterfly_top ifsb_checker u_ifsb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe)
);
